// ----- rtl/core/pbcgu_pkg.sv -----
// ----------------------------------------------------------------------------
// pbcgu_pkg
// Shared types and constants for the periodic boundary group unwrap block.
// ----------------------------------------------------------------------------
package pbcgu_pkg;

  localparam int MAX_ATOMS_DEF  = 1024;
  localparam int MAX_WRAPS_DEF  = 8;
  localparam int SHIFT_BITS_DEF = 16;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 32;
  localparam int DIAG_W  = 31;
  localparam int ACC_W   = 64;
  localparam int STEP_W  = 8;   // holds +-64
  localparam int STEPO_W = 5;
  localparam int CFG_AW  = 5;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_APPLY  = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;   // behaves as apply

  localparam logic [2:0] REG_BOX_XX = 3'd0;
  localparam logic [2:0] REG_BOX_YX = 3'd1;
  localparam logic [2:0] REG_BOX_YY = 3'd2;
  localparam logic [2:0] REG_BOX_ZX = 3'd3;
  localparam logic [2:0] REG_BOX_ZY = 3'd4;
  localparam logic [2:0] REG_BOX_ZZ = 3'd5;

  localparam logic [DIAG_W-1:0] BOX_DIAG_RST = 31'd1048576;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_WRAP  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

// ----- rtl/core/pbcgu_store.sv -----
// ----------------------------------------------------------------------------
// pbcgu_store
// Per-atom shift and reference memories, one read and one write port each.
// ----------------------------------------------------------------------------
module pbcgu_store #(
  parameter int DEPTH = pbcgu_pkg::MAX_ATOMS_DEF,
  parameter int SB    = pbcgu_pkg::SHIFT_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  pbcgu_pkg::store_ctl_t  ctl,
  input  logic [AW-1:0]          wr_addr,
  input  logic [3*SB-1:0]        wr_shift,
  input  logic [3*32-1:0]        wr_ref,
  input  logic [AW-1:0]          rd_addr,
  output logic [3*SB-1:0]        rd_shift,
  output logic [3*32-1:0]        rd_ref
);
  import pbcgu_pkg::*;

  logic [3*SB-1:0]    shift_mem [DEPTH];
  logic [3*POS_W-1:0] ref_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      shift_mem[wr_addr] <= wr_shift;
      ref_mem[wr_addr]   <= wr_ref;
    end
    if (ctl.rd_en) begin
      rd_shift <= shift_mem[rd_addr];
      rd_ref   <= ref_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/pbc_group_unwrap.sv -----
// ----------------------------------------------------------------------------
// pbc_group_unwrap
// Unwraps atom positions across a triclinic periodic box using per-atom
// saved shifts and reference positions held in on-chip memory.
// ----------------------------------------------------------------------------
// Load skips the multiplier; apply and update use it, and update adds the wrap loop.
// One word at a time; the next word is taken once the previous result is
// registered. Time per word is set by the shared multiplier, the wrap loop,
// one box-row add per cycle, and any output stall.
// Reset: synchronous; afterwards a clearing pass zeroes every shift memory
// entry, during which no input word is taken.
module pbc_group_unwrap #(
  parameter int MAX_ATOMS  = pbcgu_pkg::MAX_ATOMS_DEF,
  parameter int MAX_WRAPS  = pbcgu_pkg::MAX_WRAPS_DEF,
  parameter int SHIFT_BITS = pbcgu_pkg::SHIFT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [9:0] atom_index, [41:10] pos_x, [73:42] pos_y, [105:74] pos_z, zero pad
  input  logic [111:0] in_tdata,
  // [1:0] action
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] whole_x, [63:32] whole_y, [95:64] whole_z, [100:96] step_shift_x,
  // [105:101] step_shift_y, [110:106] step_shift_z, [111] overflow
  output logic [111:0] out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pbcgu_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import pbcgu_pkg::*;

  localparam int AW  = $clog2(MAX_ATOMS);
  localparam int SB  = SHIFT_BITS;
  localparam int NW  = $clog2(MAX_WRAPS + 1);
  localparam logic signed [SB+1:0] SMAX = (SB+2)'((1 << (SB-1)) - 1);
  localparam logic signed [SB+1:0] SMIN = -SMAX - (SB+2)'(1);

  // configuration
  logic [DIAG_W-1:0]       box_xx_r, box_yy_r, box_zz_r;
  logic signed [POS_W-1:0] box_yx_r, box_zx_r, box_zy_r;
  logic                    cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_xx_r <= BOX_DIAG_RST;
      box_yy_r <= BOX_DIAG_RST;
      box_zz_r <= BOX_DIAG_RST;
      box_yx_r <= '0;
      box_zx_r <= '0;
      box_zy_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_BOX_XX: box_xx_r <= cfg_pwdata[DIAG_W-1:0];
        REG_BOX_YX: box_yx_r <= cfg_pwdata;
        REG_BOX_YY: box_yy_r <= cfg_pwdata[DIAG_W-1:0];
        REG_BOX_ZX: box_zx_r <= cfg_pwdata;
        REG_BOX_ZY: box_zy_r <= cfg_pwdata;
        REG_BOX_ZZ: box_zz_r <= cfg_pwdata[DIAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_BOX_XX: cfg_prdata = {1'b0, box_xx_r};
      REG_BOX_YX: cfg_prdata = box_yx_r;
      REG_BOX_YY: cfg_prdata = {1'b0, box_yy_r};
      REG_BOX_ZX: cfg_prdata = box_zx_r;
      REG_BOX_ZY: cfg_prdata = box_zy_r;
      REG_BOX_ZZ: cfg_prdata = {1'b0, box_zz_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // box element (row m, column d), sign-extended
  function automatic logic signed [ACC_W-1:0] box_el(input logic [1:0] m, input logic [1:0] d);
    logic signed [ACC_W-1:0] r;
    r = '0;
    unique case ({m, d})
      4'b0000: r = ACC_W'($signed({1'b0, box_xx_r}));
      4'b0100: r = ACC_W'(box_yx_r);
      4'b0101: r = ACC_W'($signed({1'b0, box_yy_r}));
      4'b1000: r = ACC_W'(box_zx_r);
      4'b1001: r = ACC_W'(box_zy_r);
      4'b1010: r = ACC_W'($signed({1'b0, box_zz_r}));
      default: r = '0;
    endcase
    return r;
  endfunction

  // atom index modulo depth, restoring reduction
  function automatic logic [IDX_W-1:0] idx_mod(input logic [IDX_W-1:0] v);
    logic [IDX_W+17:0] t;
    t = (IDX_W+18)'(v);
    for (int k = IDX_W-1; k >= 0; k--) begin
      if (t >= (IDX_W+18)'(MAX_ATOMS << k)) t = t - (IDX_W+18)'(MAX_ATOMS << k);
    end
    return t[IDX_W-1:0];
  endfunction

  // control state
  state_t                  state_r;
  logic [AW-1:0]           clr_cnt_r;
  logic [1:0]              act_r;
  logic [AW-1:0]           addr_r;
  logic signed [POS_W-1:0] pos_r [3];
  logic signed [ACC_W-1:0] acc_r [3];
  logic [2:0]              k_r;
  logic signed [ACC_W-1:0] prod_r;
  logic [1:0]              pdst_r;
  logic                    pval_r;
  logic [1:0]              m_r;
  logic                    up_r;
  logic [NW-1:0]           n_r;
  logic signed [STEP_W-1:0] step_r [3];
  logic                    ovf_r;
  logic                    out_valid_r;
  logic [111:0]            out_data_r;

  store_ctl_t      sctl;
  logic [AW-1:0]   wr_addr;
  logic [3*SB-1:0] wr_shift, rd_shift;
  logic [3*32-1:0] wr_ref, rd_ref;
  logic            upd;

  assign upd = (act_r == ACT_UPDATE);
  assign in_tready = (state_r == ST_IDLE);

  pbcgu_store #(.DEPTH(MAX_ATOMS), .SB(SB), .AW(AW)) u_store (
    .clk      (clk),
    .ctl      (sctl),
    .wr_addr  (wr_addr),
    .wr_shift (wr_shift),
    .wr_ref   (wr_ref),
    .rd_addr  (addr_r),
    .rd_shift (rd_shift),
    .rd_ref   (rd_ref)
  );

  // multiplier operand select; box elements fit in 32 bits signed
  logic [1:0] mul_m, mul_d;
  logic signed [SB-1:0] mul_s;
  logic signed [POS_W-1:0] mul_b;
  logic signed [SB+POS_W-1:0] mul_p;
  always_comb begin
    unique case (k_r)
      3'd0:    begin mul_m = 2'd0; mul_d = 2'd0; end
      3'd1:    begin mul_m = 2'd1; mul_d = 2'd0; end
      3'd2:    begin mul_m = 2'd2; mul_d = 2'd0; end
      3'd3:    begin mul_m = 2'd1; mul_d = 2'd1; end
      3'd4:    begin mul_m = 2'd2; mul_d = 2'd1; end
      default: begin mul_m = 2'd2; mul_d = 2'd2; end
    endcase
    mul_s = $signed(rd_shift[mul_m*SB +: SB]);
    mul_b = POS_W'(box_el(mul_m, mul_d));
    mul_p = mul_s * mul_b;
  end

  // wrap test on the current axis
  logic signed [ACC_W+1:0] two_dx, bmm;
  logic                    cond, n_max;
  always_comb begin
    two_dx = (ACC_W+2)'(acc_r[m_r]) <<< 1;
    bmm    = (ACC_W+2)'(box_el(m_r, m_r));
    cond   = up_r ? (two_dx < -bmm) : (two_dx >= bmm);
    n_max  = (n_r == NW'(MAX_WRAPS));
  end

  // final values
  logic signed [ACC_W-1:0] fin_v [3];
  logic signed [POS_W-1:0] whole [3];
  logic signed [SB+1:0]    new_s [3];
  logic                    fin_ovf;
  always_comb begin
    fin_ovf = ovf_r;
    for (int d = 0; d < 3; d++) begin
      fin_v[d] = acc_r[d] + (upd ? ACC_W'($signed(rd_ref[d*32 +: 32])) : ACC_W'(0));
      if (act_r == ACT_LOAD) whole[d] = pos_r[d];
      else if (fin_v[d] > ACC_W'(32'sh7FFFFFFF)) begin
        whole[d] = 32'sh7FFFFFFF; fin_ovf = 1'b1;
      end else if (fin_v[d] < -ACC_W'(33'sh080000000)) begin
        whole[d] = 32'sh80000000; fin_ovf = 1'b1;
      end else whole[d] = fin_v[d][POS_W-1:0];
      new_s[d] = (SB+2)'($signed(rd_shift[d*SB +: SB])) + (SB+2)'(step_r[d]);
      if (upd && new_s[d] > SMAX) begin new_s[d] = SMAX; fin_ovf = 1'b1; end
      if (upd && new_s[d] < SMIN) begin new_s[d] = SMIN; fin_ovf = 1'b1; end
    end
  end

  logic fin_go;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    sctl.rd_en = (state_r == ST_READ);
    sctl.wr_en = (state_r == ST_CLEAR) ||
                 (fin_go && (act_r != ACT_APPLY) && (act_r != ACT_SPARE));
    wr_addr  = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
    wr_shift = '0;
    wr_ref   = {whole[2], whole[1], whole[0]};
    if (state_r == ST_FIN && upd) begin
      wr_shift = {new_s[2][SB-1:0], new_s[1][SB-1:0], new_s[0][SB-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(MAX_ATOMS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            act_r  <= in_tuser;
            addr_r <= AW'(idx_mod(in_tdata[9:0]));
            for (int d = 0; d < 3; d++) begin
              pos_r[d] <= $signed(in_tdata[10 + d*32 +: 32]);
              acc_r[d] <= ACC_W'($signed(in_tdata[10 + d*32 +: 32]));
              step_r[d] <= '0;
            end
            ovf_r   <= 1'b0;
            k_r     <= '0;
            pval_r  <= 1'b0;
            m_r     <= 2'd2;
            up_r    <= 1'b1;
            n_r     <= '0;
            state_r <= ST_READ;
          end
        end
        ST_READ: state_r <= (act_r == ACT_LOAD) ? ST_FIN : ST_MUL;
        ST_MUL: begin
          prod_r <= ACC_W'(mul_p);
          pdst_r <= mul_d;
          pval_r <= (k_r != 3'd6);
          if (pval_r) acc_r[pdst_r] <= acc_r[pdst_r] + prod_r;
          // k_r reaches 7 here, which marks the first wrap cycle
          k_r <= k_r + 3'd1;
          if (k_r == 3'd6) begin
            // on update, the first wrap step turns p into the move from the reference
            if (upd) state_r <= ST_WRAP;
            else state_r <= ST_FIN;
          end
        end
        ST_WRAP: begin
          if (k_r == 3'd7) begin
            k_r <= '0;
            for (int d = 0; d < 3; d++)
              acc_r[d] <= acc_r[d] - ACC_W'($signed(rd_ref[d*32 +: 32]));
          end else if (cond && !n_max) begin
            for (int d = 0; d < 3; d++)
              acc_r[d] <= up_r ? acc_r[d] + box_el(m_r, 2'(d))
                               : acc_r[d] - box_el(m_r, 2'(d));
            step_r[m_r] <= up_r ? step_r[m_r] + STEP_W'(1) : step_r[m_r] - STEP_W'(1);
            n_r <= n_r + NW'(1);
          end else begin
            if (cond) ovf_r <= 1'b1;
            n_r <= '0;
            if (up_r) up_r <= 1'b0;
            else begin
              up_r <= 1'b1;
              if (m_r == 2'd0) state_r <= ST_FIN;
              else m_r <= m_r - 2'd1;
            end
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_data_r  <= {fin_ovf && (act_r != ACT_LOAD),
                            step_r[2][STEPO_W-1:0], step_r[1][STEPO_W-1:0],
                            step_r[0][STEPO_W-1:0],
                            whole[2], whole[1], whole[0]};
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready) else $error("word taken during clear");
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_READ)) else $error("accept not followed by read");
  a_result_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FIN)) else $error("result outside finish");
`endif

endmodule
